/* hw/rtl/mccr_pkg.sv */
// ----------------------------------------------------------------------------
// mccr_pkg
// Shared types and constants of the memory card command responder.
// ----------------------------------------------------------------------------
package mccr_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_AUTH  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REPLY,
      ST_RD_WAIT,
      ST_RD_OUT,
      ST_ERASE
   } state_type;

   localparam logic [7:0] MARKER      = 8'h2b;
   localparam logic [7:0] TERM_RESET  = 8'h55;
   localparam logic [7:0] ERASED      = 8'hff;
   localparam logic [7:0] SPEC_A      = 8'h02;
   localparam logic [7:0] SPEC_B      = 8'h10;

   localparam logic [7:0] CMD_ACK_A   = 8'h11;
   localparam logic [7:0] CMD_ACK_B   = 8'h12;
   localparam logic [7:0] CMD_ACK_C   = 8'h81;
   localparam logic [7:0] CMD_ERASE_S = 8'h21;
   localparam logic [7:0] CMD_WRITE_S = 8'h22;
   localparam logic [7:0] CMD_READ_S  = 8'h23;
   localparam logic [7:0] CMD_SPECS   = 8'h26;
   localparam logic [7:0] CMD_SET_T   = 8'h27;
   localparam logic [7:0] CMD_GET_T   = 8'h28;
   localparam logic [7:0] CMD_WRITE   = 8'h42;
   localparam logic [7:0] CMD_READ    = 8'h43;
   localparam logic [7:0] CMD_ERASE   = 8'h82;
   localparam logic [7:0] CMD_AUTH    = 8'hf0;
   localparam logic [7:0] CMD_F1      = 8'hf1;
   localparam logic [7:0] CMD_F3      = 8'hf3;
   localparam logic [7:0] CMD_F7      = 8'hf7;
   localparam logic [7:0] CMD_BF      = 8'hbf;

   localparam int unsigned REPLY_MAX  = 14;
   typedef logic [3:0] rcnt_type;

endpackage

/* hw/rtl/mccr_ram.sv */
// ----------------------------------------------------------------------------
// mccr_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module mccr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/memory_card_command_responder.sv */
// ----------------------------------------------------------------------------
// memory_card_command_responder
// Card side of the serial memory card command link.
// ----------------------------------------------------------------------------
// Usage:
//  - Raise start with the req_ fields for one cycle while busy is low; the
//    transaction is taken at that edge. req_type 0 is a command header,
//    req_type 1 a data byte.
//  - Reply bytes come out one per cycle on rsp_out_byte with rsp_valid high
//    for exactly one cycle each; rsp_last marks the final byte of a
//    transaction, rsp_error flags an unsupported command. The receiver
//    cannot stall, so the byte sequencer never waits.
//  - The first reply byte follows acceptance in the next cycle; a read byte
//    first passes the RD_WAIT and RD_OUT states, since the card RAM read is
//    registered. A header reply is 4 to 14 bytes long; a write, auth or
//    read data byte gets one reply byte, or three with the trailer.
//  - Erase (0x82) replies, then fills ERASE_SECTORS*512 bytes with 0xff at
//    one byte per cycle through the single RAM port; busy stays high.
//  - csr_wr_en/csr_wr_data set sector_count; write it only while idle.
//  - Reset (synchronous) restores terminator 0x55, address 0 and idle mode;
//    card memory is never cleared.
// ----------------------------------------------------------------------------
module memory_card_command_responder #(
   parameter int CARD_BYTES    = 8388608,
   parameter int ERASE_SECTORS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [7:0]  req_cmd,
   input  logic [7:0]  req_param,
   input  logic [31:0] req_lba,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_error,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data
);

   localparam int AW          = $clog2(CARD_BYTES);
   localparam int SECTOR_BITS = 9;
   localparam int ERASE_BYTES = ERASE_SECTORS * 512;
   localparam int EW          = $clog2(ERASE_BYTES + 1);

   // reply buffer: bytes of the current transaction, played out one a cycle
   logic [7:0] rbuf_ff [mccr_pkg::REPLY_MAX];
   logic [7:0] rbuf_in [mccr_pkg::REPLY_MAX];
   mccr_pkg::rcnt_type rlen_ff, rlen_in, ridx_ff, ridx_in;
   logic rerr_ff, rerr_in;

   mccr_pkg::state_type state_ff, state_in;
   mccr_pkg::mode_type  mode_ff, mode_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    term_ff, term_in;
   logic [7:0]    left_ff, left_in;
   logic [7:0]    xor_ff, xor_in;
   logic [14:0]   scnt_ff, scnt_in;
   logic          erase_ff, erase_in;
   logic [EW-1:0] ecnt_ff, ecnt_in;

   logic          ram_we;
   logic [7:0]    ram_wd, ram_rd;
   logic [AW-1:0] addr_nx;
   logic [7:0]    spec_c;
   logic [7:0]    left_m1;
   logic [7:0]    rd_x;
   logic [AW-1:0] lba_sh;

   mccr_ram #(.WIDTH(8), .DEPTH(CARD_BYTES)) u_card (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (addr_ff),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   // wrap is natural: CARD_BYTES is a power of two
   assign addr_nx = addr_ff + AW'(1);
   assign spec_c  = mccr_pkg::SPEC_A ^ mccr_pkg::SPEC_B ^ scnt_ff[7:0] ^ {1'b0, scnt_ff[14:8]};
   assign left_m1 = left_ff - 8'd1;
   assign rd_x    = xor_ff ^ ram_rd;
   assign lba_sh  = {req_lba[AW-SECTOR_BITS-1:0], {SECTOR_BITS{1'b0}}};

   assign busy         = (state_ff != mccr_pkg::ST_IDLE);
   assign rsp_valid    = (state_ff == mccr_pkg::ST_REPLY);
   assign rsp_out_byte = rbuf_ff[ridx_ff];
   assign rsp_last     = (ridx_ff == rlen_ff - mccr_pkg::rcnt_type'(1));
   assign rsp_error    = rerr_ff;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      addr_in  = addr_ff;
      term_in  = term_ff;
      left_in  = left_ff;
      xor_in   = xor_ff;
      scnt_in  = csr_wr_en ? csr_wr_data : scnt_ff;
      erase_in = erase_ff;
      ecnt_in  = ecnt_ff;
      rbuf_in  = rbuf_ff;
      rlen_in  = rlen_ff;
      ridx_in  = ridx_ff;
      rerr_in  = rerr_ff;
      ram_we   = 1'b0;
      ram_wd   = req_data_byte;

      unique case (state_ff)
         mccr_pkg::ST_IDLE: begin
            if (start) begin
               for (int i = 0; i < mccr_pkg::REPLY_MAX; i++) rbuf_in[i] = 8'h00;
               ridx_in = '0;
               rerr_in = 1'b0;
               state_in = mccr_pkg::ST_REPLY;
               if (!req_type) begin
                  mode_in = mccr_pkg::MODE_IDLE;
                  left_in = 8'd0;
                  xor_in  = 8'd0;
                  unique case (req_cmd)
                     mccr_pkg::CMD_ACK_A, mccr_pkg::CMD_ACK_B, mccr_pkg::CMD_ACK_C: begin
                        rbuf_in[2] = mccr_pkg::MARKER; rbuf_in[3] = term_ff;
                        rlen_in = 4'd4;
                     end
                     mccr_pkg::CMD_ERASE_S, mccr_pkg::CMD_WRITE_S,
                     mccr_pkg::CMD_READ_S: begin
                        addr_in = lba_sh;
                        rbuf_in[7] = mccr_pkg::MARKER; rbuf_in[8] = term_ff;
                        rlen_in = 4'd9;
                     end
                     mccr_pkg::CMD_SPECS: begin
                        rbuf_in[2]  = mccr_pkg::MARKER;
                        rbuf_in[4]  = mccr_pkg::SPEC_A;
                        rbuf_in[5]  = mccr_pkg::SPEC_B;
                        rbuf_in[7]  = scnt_ff[7:0];
                        rbuf_in[8]  = {1'b0, scnt_ff[14:8]};
                        rbuf_in[11] = spec_c;
                        rbuf_in[12] = term_ff;
                        rlen_in = 4'd13;
                     end
                     mccr_pkg::CMD_SET_T: begin
                        rbuf_in[3] = mccr_pkg::MARKER; rbuf_in[4] = term_ff;
                        rlen_in = 4'd5;
                        term_in = req_param;
                     end
                     mccr_pkg::CMD_GET_T: begin
                        rbuf_in[2] = mccr_pkg::MARKER; rbuf_in[3] = term_ff;
                        rbuf_in[4] = mccr_pkg::TERM_RESET;
                        rlen_in = 4'd5;
                     end
                     mccr_pkg::CMD_WRITE, mccr_pkg::CMD_READ: begin
                        rbuf_in[2] = mccr_pkg::MARKER; rbuf_in[3] = term_ff;
                        rlen_in = 4'd4;
                        if (req_param == 8'd0) begin
                           // empty transfer: trailer right away, checksum 0
                           rbuf_in[5] = term_ff;
                           rlen_in = 4'd6;
                        end else begin
                           mode_in = (req_cmd == mccr_pkg::CMD_WRITE) ?
                                     mccr_pkg::MODE_WRITE : mccr_pkg::MODE_READ;
                           left_in = req_param;
                        end
                     end
                     mccr_pkg::CMD_ERASE: begin
                        rbuf_in[2] = mccr_pkg::MARKER; rbuf_in[3] = term_ff;
                        rlen_in = 4'd4;
                        erase_in = 1'b1;
                        ecnt_in = EW'(ERASE_BYTES);
                     end
                     mccr_pkg::CMD_AUTH: begin
                        unique case (req_param)
                           8'h01, 8'h02, 8'h04, 8'h0f, 8'h11, 8'h13: begin
                              rbuf_in[3] = mccr_pkg::MARKER;
                              rlen_in = 4'd4;
                              mode_in = mccr_pkg::MODE_AUTH;
                              left_in = 8'd8;
                           end
                           8'h06, 8'h07, 8'h0b: begin
                              rbuf_in[12] = mccr_pkg::MARKER; rbuf_in[13] = term_ff;
                              rlen_in = 4'd14;
                           end
                           default: begin
                              rbuf_in[3] = mccr_pkg::MARKER; rbuf_in[4] = term_ff;
                              rlen_in = 4'd5;
                           end
                        endcase
                     end
                     mccr_pkg::CMD_F3, mccr_pkg::CMD_F7, mccr_pkg::CMD_BF,
                     mccr_pkg::CMD_F1: begin
                        rbuf_in[3] = mccr_pkg::MARKER; rbuf_in[4] = term_ff;
                        rlen_in = 4'd5;
                        rerr_in = (req_cmd == mccr_pkg::CMD_F1);
                     end
                     default: begin
                        rbuf_in[2] = mccr_pkg::MARKER; rbuf_in[3] = term_ff;
                        rlen_in = 4'd4;
                        rerr_in = 1'b1;
                     end
                  endcase
               end else begin
                  unique case (mode_ff)
                     mccr_pkg::MODE_IDLE: begin
                        state_in = mccr_pkg::ST_IDLE;
                     end
                     mccr_pkg::MODE_WRITE: begin
                        ram_we  = 1'b1;
                        addr_in = addr_nx;
                        left_in = left_m1;
                        rlen_in = 4'd1;
                        if (left_m1 == 8'd0) begin
                           rbuf_in[2] = term_ff;
                           rlen_in = 4'd3;
                           mode_in = mccr_pkg::MODE_IDLE;
                        end
                     end
                     mccr_pkg::MODE_READ: begin
                        // RAM read issued at addr_ff; data next cycle
                        state_in = mccr_pkg::ST_RD_WAIT;
                     end
                     mccr_pkg::MODE_AUTH: begin
                        xor_in  = xor_ff ^ req_data_byte;
                        left_in = left_m1;
                        rlen_in = 4'd1;
                        if (left_m1 == 8'd0) begin
                           rbuf_in[1] = xor_ff ^ req_data_byte;
                           rbuf_in[2] = term_ff;
                           rlen_in = 4'd3;
                           mode_in = mccr_pkg::MODE_IDLE;
                        end
                     end
                     default: state_in = mccr_pkg::ST_IDLE;
                  endcase
               end
            end
         end
         mccr_pkg::ST_RD_WAIT: begin
            state_in = mccr_pkg::ST_RD_OUT;
         end
         mccr_pkg::ST_RD_OUT: begin
            rbuf_in[0] = ram_rd;
            xor_in  = rd_x;
            addr_in = addr_nx;
            left_in = left_m1;
            rlen_in = 4'd1;
            if (left_m1 == 8'd0) begin
               rbuf_in[1] = rd_x;
               rbuf_in[2] = term_ff;
               rlen_in = 4'd3;
               mode_in = mccr_pkg::MODE_IDLE;
            end
            state_in = mccr_pkg::ST_REPLY;
         end
         mccr_pkg::ST_REPLY: begin
            ridx_in = ridx_ff + mccr_pkg::rcnt_type'(1);
            if (rsp_last) begin
               state_in = erase_ff ? mccr_pkg::ST_ERASE : mccr_pkg::ST_IDLE;
            end
         end
         mccr_pkg::ST_ERASE: begin
            ram_we  = 1'b1;
            ram_wd  = mccr_pkg::ERASED;
            addr_in = addr_nx;
            ecnt_in = ecnt_ff - EW'(1);
            if (ecnt_ff == EW'(1)) begin
               erase_in = 1'b0;
               state_in = mccr_pkg::ST_IDLE;
            end
         end
         default: state_in = mccr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mccr_pkg::ST_IDLE;
         mode_ff  <= mccr_pkg::MODE_IDLE;
         addr_ff  <= '0;
         term_ff  <= mccr_pkg::TERM_RESET;
         left_ff  <= 8'd0;
         xor_ff   <= 8'd0;
         scnt_ff  <= 15'd16384;
         erase_ff <= 1'b0;
         ecnt_ff  <= '0;
         ridx_ff  <= '0;
         rlen_ff  <= '0;
         rerr_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         addr_ff  <= addr_in;
         term_ff  <= term_in;
         left_ff  <= left_in;
         xor_ff   <= xor_in;
         scnt_ff  <= scnt_in;
         erase_ff <= erase_in;
         ecnt_ff  <= ecnt_in;
         ridx_ff  <= ridx_in;
         rlen_ff  <= rlen_in;
         rerr_ff  <= rerr_in;
      end
      rbuf_ff <= rbuf_in;
   end

endmodule

/* dv/memory_card_command_responder_tb.sv */
// ----------------------------------------------------------------------------
// memory_card_command_responder_tb
// Drives command headers and data bytes into the card responder and checks
// every reply byte against a predictor of the card protocol.
// ----------------------------------------------------------------------------
module memory_card_command_responder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] rbyte;
      logic       rlast;
      logic       rerr;
   } reply_type;

   // Predictor of the card: state, card image and the queue of reply bytes
   // still owed by the block.
   class card_scoreboard;
      bit [7:0]  card_mem [bit [22:0]];
      bit [22:0] addr;
      bit [7:0]  term;
      mccr_pkg::mode_type mode;
      bit [7:0]  left;
      bit [7:0]  xsum;
      bit [14:0] scount;
      reply_type owed [$];
      reply_type cur [$];
      int        errors;

      function void clear_state();
         addr = '0; term = mccr_pkg::TERM_RESET; mode = mccr_pkg::MODE_IDLE;
         left = '0; xsum = '0; scount = 15'd16384;
      endfunction

      function void put(bit [7:0] b);
         reply_type r;
         r.rbyte = b; r.rlast = 1'b0; r.rerr = 1'b0;
         cur.push_back(r);
      endfunction

      function void zeros(int n);
         for (int i = 0; i < n; i++) put(8'h00);
      endfunction

      function bit [7:0] rd(bit [22:0] a);
         return card_mem.exists(a) ? card_mem[a] : 8'h00;
      endfunction

      function bit readable(int n);
         for (int i = 0; i < n; i++)
            if (!card_mem.exists(addr + 23'(i))) return 1'b0;
         return 1'b1;
      endfunction

      function void trailer();
         if (mode == mccr_pkg::MODE_WRITE) begin
            put(8'h00); put(term);
         end else begin
            put(xsum); put(term);
         end
         mode = mccr_pkg::MODE_IDLE;
      endfunction

      function bit header(bit [7:0] cmd, bit [7:0] param, bit [31:0] lba);
         bit [7:0] c;
         mode = mccr_pkg::MODE_IDLE; left = '0; xsum = '0;
         case (cmd)
            mccr_pkg::CMD_ACK_A, mccr_pkg::CMD_ACK_B, mccr_pkg::CMD_ACK_C: begin
               zeros(2); put(mccr_pkg::MARKER); put(term);
            end
            mccr_pkg::CMD_ERASE_S, mccr_pkg::CMD_WRITE_S, mccr_pkg::CMD_READ_S: begin
               addr = {lba[13:0], 9'd0};
               zeros(7); put(mccr_pkg::MARKER); put(term);
            end
            mccr_pkg::CMD_SPECS: begin
               c = mccr_pkg::SPEC_A ^ mccr_pkg::SPEC_B ^ scount[7:0] ^ {1'b0, scount[14:8]};
               zeros(2); put(mccr_pkg::MARKER); put(8'h00);
               put(mccr_pkg::SPEC_A); put(mccr_pkg::SPEC_B);
               put(8'h00); put(scount[7:0]); put({1'b0, scount[14:8]});
               put(8'h00); put(8'h00); put(c); put(term);
            end
            mccr_pkg::CMD_SET_T: begin
               zeros(3); put(mccr_pkg::MARKER); put(term);
               term = param;
            end
            mccr_pkg::CMD_GET_T: begin
               zeros(2); put(mccr_pkg::MARKER); put(term); put(mccr_pkg::TERM_RESET);
            end
            mccr_pkg::CMD_WRITE, mccr_pkg::CMD_READ: begin
               zeros(2); put(mccr_pkg::MARKER); put(term);
               mode = (cmd == mccr_pkg::CMD_WRITE) ? mccr_pkg::MODE_WRITE
                                                   : mccr_pkg::MODE_READ;
               left = param;
               if (left == 0) trailer();
            end
            mccr_pkg::CMD_ERASE: begin
               zeros(2); put(mccr_pkg::MARKER); put(term);
               for (int i = 0; i < 16 * 512; i++) begin
                  card_mem[addr] = mccr_pkg::ERASED;
                  addr++;
               end
            end
            mccr_pkg::CMD_AUTH: begin
               case (param)
                  8'h01, 8'h02, 8'h04, 8'h0f, 8'h11, 8'h13: begin
                     zeros(3); put(mccr_pkg::MARKER);
                     mode = mccr_pkg::MODE_AUTH; left = 8'd8;
                  end
                  8'h06, 8'h07, 8'h0b: begin
                     zeros(12); put(mccr_pkg::MARKER); put(term);
                  end
                  default: begin
                     zeros(3); put(mccr_pkg::MARKER); put(term);
                  end
               endcase
            end
            mccr_pkg::CMD_F3, mccr_pkg::CMD_F7, mccr_pkg::CMD_BF, mccr_pkg::CMD_F1: begin
               zeros(3); put(mccr_pkg::MARKER); put(term);
               return cmd == mccr_pkg::CMD_F1;
            end
            default: begin
               zeros(2); put(mccr_pkg::MARKER); put(term);
               return 1'b1;
            end
         endcase
         return 1'b0;
      endfunction

      function void data(bit [7:0] b);
         bit [7:0] v;
         if (mode == mccr_pkg::MODE_IDLE || left == 0) begin
            mode = mccr_pkg::MODE_IDLE;
            return;
         end
         if (mode == mccr_pkg::MODE_WRITE) begin
            card_mem[addr] = b; addr++; put(8'h00);
         end else if (mode == mccr_pkg::MODE_READ) begin
            v = rd(addr); addr++; xsum ^= v; put(v);
         end else begin
            xsum ^= b; put(8'h00);
         end
         left--;
         if (left == 0) trailer();
      endfunction

      // accepted transaction: work out its reply bytes
      function void note(bit typ, bit [7:0] cmd, bit [7:0] param, bit [31:0] lba,
                         bit [7:0] db);
         bit err;
         err = 1'b0;
         cur.delete();
         if (!typ) err = header(cmd, param, lba);
         else data(db);
         foreach (cur[k]) begin
            cur[k].rerr = err;
            if (k == cur.size() - 1) cur[k].rlast = 1'b1;
            owed.push_back(cur[k]);
         end
      endfunction

      function void check(logic [7:0] b, logic l, logic e);
         reply_type x;
         if (owed.size() == 0) begin
            $error("reply byte %h with nothing outstanding", b);
            errors++;
            return;
         end
         x = owed.pop_front();
         if (b !== x.rbyte) begin
            $error("out_byte: expected %h, actual %h", x.rbyte, b); errors++;
         end
         if (l !== x.rlast) begin
            $error("last: expected %b, actual %b", x.rlast, l); errors++;
         end
         if (e !== x.rerr) begin
            $error("error: expected %b, actual %b", x.rerr, e); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = 1'b0;
   logic [7:0]  req_cmd = '0;
   logic [7:0]  req_param = '0;
   logic [31:0] req_lba = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_error;
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;

   card_scoreboard sb;
   int items_sent;
   int erase_budget;
   int quiet_cycles;

   memory_card_command_responder uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_cmd(req_cmd), .req_param(req_param),
      .req_lba(req_lba), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last), .rsp_error(rsp_error),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Monitor: transactions in, reply bytes out, both at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note(req_type, req_cmd, req_param, req_lba, req_data_byte);
         if (rsp_valid)
            sb.check(rsp_out_byte, rsp_last, rsp_error);
      end
   end

   // Watchdog: the erase fill produces no replies, so the limit sits well above it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 60000) begin
         $display("** memory_card_command_responder: FAILED **");
         $finish;
      end
   end

   // one transaction; start stays high unless a gap follows
   task automatic send(bit typ, bit [7:0] cmd, bit [7:0] param, bit [31:0] lba,
                       bit [7:0] db);
      @(negedge clock);
      start = 1'b1; req_type = typ; req_cmd = cmd; req_param = param;
      req_lba = lba; req_data_byte = db;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic hdr(bit [7:0] cmd, bit [7:0] param = 8'h00, bit [31:0] lba = 0);
      send(1'b0, cmd, param, lba, 8'($urandom));
   endtask

   task automatic dat(bit [7:0] db);
      send(1'b1, 8'($urandom), 8'($urandom), $urandom, db);
   endtask

   // mostly back to back, now and then a long pause
   task automatic idle_gap();
      int r, n;
      r = $urandom_range(0, 99);
      if (r < 50) n = 0;
      else if (r < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // drain: every owed byte out and the block no longer busy (erase tail)
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.owed.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_capacity(bit [14:0] v);
      drain();
      @(negedge clock);
      csr_wr_en = 1'b1; csr_wr_data = v;
      sb.scount = v;
      @(negedge clock);
      csr_wr_en = 1'b0; csr_wr_data = 15'($urandom);
   endtask

   // sector numbers whose bytes are erased up front: 0..15 and 16376..16383,
   // with random high bits that the card drops
   function automatic bit [31:0] known_lba();
      bit [31:0] l;
      l = $urandom;
      l[13:0] = ($urandom_range(0, 1)) ? 14'($urandom_range(0, 15))
                                        : 14'($urandom_range(16376, 16383));
      return l;
   endfunction

   function automatic bit [7:0] xfer_size();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(1, 24));
   endfunction

   task automatic rand_write_seq();
      int n, stop;
      hdr(mccr_pkg::CMD_WRITE_S, 8'($urandom),
          ($urandom_range(0, 2) == 0) ? $urandom : known_lba());
      idle_gap();
      n = xfer_size();
      hdr(mccr_pkg::CMD_WRITE, 8'(n));
      stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n;
      for (int i = 0; i < stop; i++) begin
         idle_gap();
         dat(8'($urandom));
      end
   endtask

   task automatic rand_read_seq();
      int n, stop;
      n = xfer_size();
      if ($urandom_range(0, 1) == 0 || !sb.readable(n)) begin
         hdr(mccr_pkg::CMD_READ_S, 8'($urandom), known_lba());
         idle_gap();
      end
      hdr(mccr_pkg::CMD_READ, 8'(n));
      stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n;
      for (int i = 0; i < stop; i++) begin
         idle_gap();
         dat(8'($urandom));
      end
   endtask

   task automatic rand_auth_seq();
      bit [7:0] subs [6] = '{8'h01, 8'h02, 8'h04, 8'h0f, 8'h11, 8'h13};
      int stop;
      hdr(mccr_pkg::CMD_AUTH, subs[$urandom_range(0, 5)]);
      stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 8;
      for (int i = 0; i < stop; i++) begin
         idle_gap();
         dat(8'($urandom));
      end
   endtask

   task automatic rand_single();
      bit [7:0] cmds [19] = '{mccr_pkg::CMD_ACK_A, mccr_pkg::CMD_ACK_B,
                              mccr_pkg::CMD_ACK_C, mccr_pkg::CMD_ERASE_S,
                              mccr_pkg::CMD_WRITE_S, mccr_pkg::CMD_READ_S,
                              mccr_pkg::CMD_SPECS, mccr_pkg::CMD_SET_T,
                              mccr_pkg::CMD_GET_T, mccr_pkg::CMD_AUTH,
                              mccr_pkg::CMD_AUTH, mccr_pkg::CMD_F1,
                              mccr_pkg::CMD_F3, mccr_pkg::CMD_F7,
                              mccr_pkg::CMD_BF, mccr_pkg::CMD_SPECS,
                              mccr_pkg::CMD_GET_T, mccr_pkg::CMD_AUTH,
                              mccr_pkg::CMD_ACK_A};
      bit [7:0] c, p;
      c = ($urandom_range(0, 2) == 0) ? 8'($urandom) : cmds[$urandom_range(0, 18)];
      p = 8'($urandom);
      if (c == mccr_pkg::CMD_ERASE) begin
         if (erase_budget > 0) erase_budget--;
         else c = mccr_pkg::CMD_ACK_B;
      end
      // transfers are opened by the sequences above only
      if (c == mccr_pkg::CMD_READ || c == mccr_pkg::CMD_WRITE) p = 8'h00;
      hdr(c, p, $urandom);
   endtask

   initial begin
      bit [14:0] caps [5] = '{15'd1, 15'd32767, 15'd0, 15'd16384, 15'd12345};
      int phase;
      sb = new();
      sb.clear_state();
      sb.errors = 0;
      items_sent = 0;
      erase_budget = 3;
      phase = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----
      hdr(mccr_pkg::CMD_SPECS);               // reset capacity
      hdr(mccr_pkg::CMD_ACK_A); hdr(mccr_pkg::CMD_ACK_B); hdr(mccr_pkg::CMD_ACK_C);
      hdr(mccr_pkg::CMD_ERASE_S, 8'h00, 32'h0000_0000);
      hdr(mccr_pkg::CMD_ERASE);               // sectors 0..15
      hdr(mccr_pkg::CMD_ERASE_S, 8'hff, 32'hffff_fff8);  // sector 16376, high bits dropped
      hdr(mccr_pkg::CMD_ERASE);               // fill wraps past the card end
      drain();
      hdr(mccr_pkg::CMD_GET_T);
      hdr(mccr_pkg::CMD_SET_T, 8'h00); hdr(mccr_pkg::CMD_GET_T);
      hdr(mccr_pkg::CMD_SET_T, 8'hff);
      hdr(mccr_pkg::CMD_WRITE, 8'h00);        // zero size write
      hdr(mccr_pkg::CMD_READ, 8'h00);         // zero size read
      hdr(mccr_pkg::CMD_WRITE_S, 8'h00, 32'h0000_3fff);  // last sector
      hdr(mccr_pkg::CMD_WRITE, 8'd3); dat(8'hff); dat(8'h00); dat(8'ha5);
      hdr(mccr_pkg::CMD_READ_S, 8'h00, 32'h0000_3fff);
      hdr(mccr_pkg::CMD_READ, 8'd3); dat(8'h00); dat(8'h00); dat(8'h00);
      hdr(mccr_pkg::CMD_AUTH, 8'h01);
      for (int i = 0; i < 8; i++) dat(8'(1 << i));
      hdr(mccr_pkg::CMD_AUTH, 8'h06); hdr(mccr_pkg::CMD_AUTH, 8'h99);
      hdr(mccr_pkg::CMD_F1); hdr(mccr_pkg::CMD_F3);
      hdr(mccr_pkg::CMD_F7); hdr(mccr_pkg::CMD_BF);
      hdr(8'h00); hdr(8'hff);                 // unknown commands
      send(1'b1, 8'h00, 8'h00, 0, 8'h5a);     // data with no transfer
      hdr(mccr_pkg::CMD_WRITE, 8'd5); dat(8'h11); dat(8'h22);
      hdr(mccr_pkg::CMD_ACK_A);               // header abandons the write
      hdr(mccr_pkg::CMD_SET_T, mccr_pkg::TERM_RESET);

      // ---- random part, capacity changed between phases ----
      while (items_sent < 260) begin
         if (items_sent >= 60 + phase * 40 && phase < 5) begin
            set_capacity(caps[phase]);
            phase++;
            hdr(mccr_pkg::CMD_SPECS);
         end
         case ($urandom_range(0, 9))
            0, 1, 2: rand_write_seq();
            3, 4, 5: rand_read_seq();
            6:       rand_auth_seq();
            7, 8:    rand_single();
            default: begin
               if (sb.mode != mccr_pkg::MODE_READ) send(1'b1, 8'($urandom),
                                                        8'($urandom), $urandom,
                                                        8'($urandom));
               else rand_single();
            end
         endcase
         idle_gap();
         // let everything come out once mid run
         if (phase == 2 && items_sent % 40 == 0) drain();
      end

      drain();
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("** memory_card_command_responder: PASSED **");
      end else begin
         $display("** memory_card_command_responder: FAILED **");
      end
      $finish;
   end

endmodule
